// ----- rtl/cstm_pkg.sv -----
// Shared types and constants for the CAN speed threshold monitor.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package cstm_pkg;

  // Field widths of the frame and result transactions.
  localparam int unsigned ID_W       = 11;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned STAMP_W    = 24;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned THRESH_W   = 11;
  localparam int unsigned PULSE_W    = 4;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TIME_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN  = 2'd3;

  // Register reset values.
  localparam logic [ID_W-1:0]     RST_TIME_ID   = 11'd769;
  localparam logic [ID_W-1:0]     RST_SPEED_ID  = 11'd770;
  localparam logic [THRESH_W-1:0] RST_THRESHOLD = 11'd60;
  localparam logic [PULSE_W-1:0]  RST_PULSE_LEN = 4'd10;

  // Frame qualifier: only eight-byte frames carry data we use.
  localparam logic [LEN_W-1:0] FULL_LENGTH = 4'd8;

  // Speed scale: raw * 1852 / 100000.
  localparam logic [26:0] SPEED_SCALE = 27'd1852;

  // Reciprocals for exact division by constants: floor(x / d) equals
  // (x * M) >> S for every x in the range that reaches each divider.
  localparam logic [27:0] RECIP_1E5 = 28'd175921861;  // shift 44
  localparam logic [27:0] RECIP_1E3 = 28'd137438954;  // shift 37
  localparam logic [24:0] RECIP_100 = 25'd21474837;   // shift 31
  localparam logic [18:0] RECIP_60  = 19'd279621;     // shift 24
  localparam logic [17:0] RECIP_10  = 18'd209716;     // shift 21

  // Queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  // Received frame.
  typedef struct packed {
    logic [ID_W-1:0]  frame_id;
    logic             is_data_frame;
    logic             is_standard;
    logic [LEN_W-1:0] data_length;
    logic [7:0]       byte_one;
    logic [7:0]       byte_two;
    logic [7:0]       byte_three;
    logic [7:0]       byte_four;
    logic [7:0]       byte_five;
  } frame_t;

  // Result of one speed frame.
  typedef struct packed {
    logic            periodic_report;
    logic            crossing_report;
    logic [5:0]      hours;
    logic [5:0]      minutes;
    logic [5:0]      seconds;
    logic [6:0]      time_hundredths;
    logic [10:0]     speed_whole;
    logic [6:0]      speed_hundredths;
    logic            over_threshold;
    logic            report_lamp;
  } result_t;

  // Configuration registers as seen by the front and back parts.
  typedef struct packed {
    logic [ID_W-1:0]     time_id;
    logic [ID_W-1:0]     speed_id;
    logic [THRESH_W-1:0] threshold;
    logic [PULSE_W-1:0]  pulse_len;
  } cfg_t;

  // One speed frame waiting for the back part.
  typedef struct packed {
    logic [RAW_W-1:0]   raw;
    logic [STAMP_W-1:0] stamp;
  } job_t;

endpackage

`default_nettype wire

// ----- rtl/cstm_front.sv -----
// Front part: accepts frames, keeps the timestamp and queues speed frames.
// Depends on cstm_pkg.
`default_nettype none

module cstm_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cstm_pkg::cfg_t cfg,
  input  wire logic           frame_valid,
  output logic                frame_stall,
  input  wire cstm_pkg::frame_t frame,
  input  wire logic           queue_full,
  output logic                push,
  output cstm_pkg::job_t      push_job
);

  logic [cstm_pkg::STAMP_W-1:0] stamp;
  logic [cstm_pkg::STAMP_W-1:0] stamp_next;
  logic                         accept;
  logic                         qualified;
  logic                         time_hit;
  logic                         speed_hit;

  // A frame is taken whenever the queue has room.
  assign frame_stall = queue_full;
  assign accept      = frame_valid && !queue_full;

  // Classify the frame against the two configured identifiers.
  assign qualified = frame.is_data_frame && frame.is_standard &&
                     (frame.data_length == cstm_pkg::FULL_LENGTH);
  assign time_hit  = qualified && (frame.frame_id == cfg.time_id);
  assign speed_hit = qualified && (frame.frame_id == cfg.speed_id);

  // A timestamp frame replaces the stored time before any speed use.
  always_comb begin
    stamp_next = stamp;
    if (accept && time_hit) begin
      stamp_next = {frame.byte_one, frame.byte_two, frame.byte_three};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stamp <= '0;
    end else begin
      stamp <= stamp_next;
    end
  end

  // Speed frames go to the queue with the time that applies to them.
  assign push           = accept && speed_hit;
  assign push_job.raw   = {frame.byte_four, frame.byte_five};
  assign push_job.stamp = stamp_next;

endmodule

`default_nettype wire

// ----- rtl/cstm_queue.sv -----
// Short first-in first-out queue between the front and back parts.
// Depends on cstm_pkg.
`default_nettype none

module cstm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cstm_pkg::job_t push_job,
  output logic                full,
  output logic                head_valid,
  output cstm_pkg::job_t      head_job,
  input  wire logic           pop
);

  cstm_pkg::job_t                   entries [cstm_pkg::QUEUE_DEPTH];
  logic [cstm_pkg::QUEUE_PTR_W-1:0] wr_ptr;
  logic [cstm_pkg::QUEUE_PTR_W-1:0] rd_ptr;
  logic [cstm_pkg::QUEUE_CNT_W-1:0] count;
  logic                             do_push;
  logic                             do_pop;

  assign full       = (count == cstm_pkg::QUEUE_CNT_W'(cstm_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cstm_back.sv -----
// Back part: scales the speed, splits the time and keeps the alarm and lamp state.
// Depends on cstm_pkg.
`default_nettype none

module cstm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cstm_pkg::cfg_t cfg,
  input  wire logic           head_valid,
  input  wire cstm_pkg::job_t head_job,
  output logic                pop,
  output logic                result_valid,
  input  wire logic           result_stall,
  output cstm_pkg::result_t   result
);

  logic advance;

  // Stage 1 registers.
  logic        v1;
  logic [26:0] scaled_1;
  logic [23:0] stamp_1;
  logic [17:0] t100_1;

  // Stage 2 registers.
  logic        v2;
  logic [10:0] whole_2;
  logic [16:0] k1000_2;
  logic [17:0] t100_2;
  logic [6:0]  hund_2;
  logic [11:0] mt_2;
  logic [14:0] tens_2;

  // Stage 3 registers.
  logic        v3;
  logic [10:0] whole_3;
  logic [6:0]  frac_3;
  logic [6:0]  hund_3;
  logic [5:0]  secs_3;
  logic [11:0] mt_3;
  logic [5:0]  hr_3;
  logic        periodic_3;

  // Persistent state of the alarm and lamp.
  logic                          prev_over;
  logic [cstm_pkg::PULSE_W-1:0]  pulse_count;
  logic                          lamp_on;
  logic                          over;
  logic [cstm_pkg::PULSE_W-1:0]  pulse_count_next;
  logic                          lamp_on_next;

  // Products.
  logic [48:0] p_t100;
  logic [54:0] p_whole;
  logic [54:0] p_k1000;
  logic [36:0] p_mt;
  logic [35:0] p_tens;
  logic [30:0] p_hr;

  // The whole pipeline moves unless a finished result is held.
  assign advance = !(result_valid && result_stall);
  assign pop     = head_valid && advance;

  // Stage 1: speed scaling and time in whole seconds.
  assign p_t100 = 49'(head_job.stamp) * 49'(cstm_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    if (advance) begin
      scaled_1 <= 27'(head_job.raw) * cstm_pkg::SPEED_SCALE;
      stamp_1  <= head_job.stamp;
      t100_1   <= p_t100[48:31];
    end
  end

  // Stage 2: whole speed, speed in hundredths, time hundredths, minutes total, tens of seconds.
  assign p_whole = 55'(scaled_1) * 55'(cstm_pkg::RECIP_1E5);
  assign p_k1000 = 55'(scaled_1) * 55'(cstm_pkg::RECIP_1E3);
  assign p_mt    = 37'(t100_1) * 37'(cstm_pkg::RECIP_60);
  assign p_tens  = 36'(t100_1) * 36'(cstm_pkg::RECIP_10);

  always_ff @(posedge clk) begin
    if (advance) begin
      whole_2 <= p_whole[54:44];
      k1000_2 <= p_k1000[53:37];
      t100_2  <= t100_1;
      hund_2  <= 7'(stamp_1 - 24'(t100_1) * 24'd100);
      mt_2    <= p_mt[35:24];
      tens_2  <= p_tens[35:21];
    end
  end

  // Stage 3: speed hundredths, seconds, hours and the periodic test.
  assign p_hr = 31'(mt_2) * 31'(cstm_pkg::RECIP_60);

  always_ff @(posedge clk) begin
    if (advance) begin
      whole_3    <= whole_2;
      frac_3     <= 7'(k1000_2 - 17'(whole_2) * 17'd100);
      hund_3     <= hund_2;
      secs_3     <= 6'(t100_2 - 18'(mt_2) * 18'd60);
      mt_3       <= mt_2;
      hr_3       <= p_hr[29:24];
      periodic_3 <= (hund_2 == '0) && (t100_2 == 18'(tens_2) * 18'd10);
    end
  end

  // Alarm and lamp update for the frame leaving stage 3.
  assign over = (whole_3 >= cfg.threshold);

  always_comb begin
    pulse_count_next = pulse_count;
    lamp_on_next     = lamp_on;
    if (pulse_count == '0) begin
      lamp_on_next = 1'b0;
    end else begin
      pulse_count_next = pulse_count - 1'b1;
    end
    if (periodic_3) begin
      lamp_on_next     = 1'b1;
      pulse_count_next = cfg.pulse_len;
    end
  end

  // Valid bits and state.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
      prev_over    <= 1'b0;
      pulse_count  <= cstm_pkg::PULSE_W'(1);
      lamp_on      <= 1'b0;
    end else if (advance) begin
      v1           <= head_valid;
      v2           <= v1;
      v3           <= v2;
      result_valid <= v3;
      if (v3) begin
        prev_over   <= over;
        pulse_count <= pulse_count_next;
        lamp_on     <= lamp_on_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (advance) begin
      result.periodic_report  <= periodic_3;
      result.crossing_report  <= over ^ prev_over;
      result.hours            <= hr_3;
      result.minutes          <= 6'(mt_3 - 12'(hr_3) * 12'd60);
      result.seconds          <= secs_3;
      result.time_hundredths  <= hund_3;
      result.speed_whole      <= whole_3;
      result.speed_hundredths <= frac_3;
      result.over_threshold   <= over;
      result.report_lamp      <= lamp_on_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/can_speed_threshold_monitor.sv -----
// Top level of the CAN speed threshold monitor: configuration registers and wiring.
// Depends on cstm_pkg, cstm_front, cstm_queue and cstm_back.
//
// The monitor takes one received frame per clock cycle while the queue is not full.
// Timestamp frames update the stored time at once; each speed frame is written into
// the queue at the accepting edge, then passes the three arithmetic stages of the back
// part and its output register, and results leave at one per cycle while result_stall
// is low. A four-entry queue sits between frame intake and the pipeline, so frames
// keep being taken while a result is held by result_stall until the queue fills.
// Configuration writes take effect on the next cycle and are meant to be made while
// no frame is in flight.
`default_nettype none

module can_speed_threshold_monitor (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                frame_valid,
  output logic                                     frame_stall,
  input  wire cstm_pkg::frame_t                    frame,
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output cstm_pkg::result_t                        result,
  input  wire logic                                cfg_write,
  input  wire logic [cstm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cstm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  cstm_pkg::cfg_t cfg;
  logic           queue_full;
  logic           push;
  cstm_pkg::job_t push_job;
  logic           head_valid;
  cstm_pkg::job_t head_job;
  logic           pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.time_id   <= cstm_pkg::RST_TIME_ID;
      cfg.speed_id  <= cstm_pkg::RST_SPEED_ID;
      cfg.threshold <= cstm_pkg::RST_THRESHOLD;
      cfg.pulse_len <= cstm_pkg::RST_PULSE_LEN;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cstm_pkg::REG_TIME_ID:   cfg.time_id   <= cfg_data;
        cstm_pkg::REG_SPEED_ID:  cfg.speed_id  <= cfg_data;
        cstm_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data;
        cstm_pkg::REG_PULSE_LEN: cfg.pulse_len <= cfg_data[cstm_pkg::PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame intake and classification.
  cstm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .frame       (frame),
    .queue_full  (queue_full),
    .push        (push),
    .push_job    (push_job)
  );

  // Queue of pending speed frames.
  cstm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  // Arithmetic pipeline and output register.
  cstm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
